// ===== sv/b62txt_pkg.sv =====
`default_nettype none

package b62txt_pkg;

    localparam int unsigned VALUE_W   = 32;
    localparam int unsigned CHAR_W    = 7;
    localparam int unsigned BL_W      = 7;
    localparam int unsigned DIG_W     = 6;
    localparam int unsigned MAX_DIG   = 6;
    localparam int unsigned CNT_W     = 3;
    localparam int unsigned QUO_W     = 27;
    localparam int unsigned PROD_W    = 64;
    localparam int unsigned RECIP_SH  = 37;

    // floor(2^37 / 62): quotient estimate is exact or one short
    localparam logic [VALUE_W-1:0] RECIP_62   = 32'd2216757314;
    localparam logic [DIG_W:0]     RADIX      = 7'd62;
    localparam logic [BL_W-1:0]    BL_RESET   = 7'd64;
    localparam logic [CHAR_W-1:0]  CHAR_MINUS = 7'h2d;
    localparam logic [CHAR_W-1:0]  CHAR_NONE  = 7'h00;

    typedef struct packed {
        logic load;
        logic mul;
        logic fix;
        logic emit;
    } t_cmd;

    typedef struct packed {
        logic quo_zero;
        logic last;
    } t_stat;

    // digit values 0..61 map to 0-9, a-z, A-Z
    function automatic logic [CHAR_W-1:0] digit_char(input logic [DIG_W-1:0] d);
        logic [CHAR_W-1:0] dx;
        dx = {1'b0, d};
        if (dx < 7'd10) begin
            digit_char = dx + 7'h30;
        end else if (dx < 7'd36) begin
            digit_char = dx + 7'd87;
        end else begin
            digit_char = dx + 7'd29;
        end
    endfunction

endpackage

`default_nettype wire

// ===== sv/int_to_base62_text_top.sv =====
`default_nettype none

// Base-62 text encoder. Each request carries a signed 32-bit value; the block
// returns its text one character per result, most significant digit first,
// with '-' ahead of negative values and is_last on the final character. The
// most negative value encodes its full magnitude of 2^31. If the text has
// buffer_length or more characters, a single result with too_long set and a
// zero character code is returned instead. Digits come from a divide-by-62
// unit built on a 32x32 reciprocal multiply followed by a correction step,
// least significant first; characters are then sent from a six-entry digit
// store. The next request is taken while the last character still waits in
// the output register. The buffer_length register resets to 64 and may be
// written at any time the block is idle.
module int_to_base62_text_top (
    input  wire logic                            i_clk,
    input  wire logic                            i_rst_n,
    input  wire logic                            i_cfg_valid,
    output logic                                 o_cfg_ready,
    input  wire logic [b62txt_pkg::BL_W-1:0]     i_cfg_data,
    input  wire logic                            i_valid,
    output logic                                 o_ready,
    input  wire logic signed [b62txt_pkg::VALUE_W-1:0] i_value,
    output logic                                 o_valid,
    input  wire logic                            i_ready,
    output logic [b62txt_pkg::CHAR_W-1:0]        o_char_code,
    output logic                                 o_is_last,
    output logic                                 o_too_long
);
    import b62txt_pkg::*;

    t_cmd  cmd;
    t_stat stat;

    assign o_cfg_ready = 1'b1;

    b62txt_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .o_ready (o_ready),
        .o_valid (o_valid),
        .i_ready (i_ready),
        .i_stat  (stat),
        .o_cmd   (cmd)
    );

    b62txt_dp u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_valid),
        .i_cfg_data  (i_cfg_data),
        .i_value     (i_value),
        .i_cmd       (cmd),
        .o_stat      (stat),
        .o_char_code (o_char_code),
        .o_is_last   (o_is_last),
        .o_too_long  (o_too_long)
    );

    a_err_alone: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_too_long |-> o_is_last && o_char_code == CHAR_NONE)
        else $error("error result not alone");

    a_char_nonzero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !o_too_long |-> o_char_code != CHAR_NONE)
        else $error("character result with null code");

    a_busy_after_req: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid && o_ready |=> !o_ready)
        else $error("request taken while busy");

endmodule

`default_nettype wire

// ===== sv/b62txt_dp.sv =====
`default_nettype none

module b62txt_dp (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic                          i_cfg_we,
    input  wire logic [b62txt_pkg::BL_W-1:0]   i_cfg_data,
    input  wire logic [b62txt_pkg::VALUE_W-1:0] i_value,
    input  wire b62txt_pkg::t_cmd              i_cmd,
    output b62txt_pkg::t_stat                  o_stat,
    output logic [b62txt_pkg::CHAR_W-1:0]      o_char_code,
    output logic                               o_is_last,
    output logic                               o_too_long
);
    import b62txt_pkg::*;

    logic [BL_W-1:0]    r_bl;
    logic [VALUE_W-1:0] r_mag;
    logic               r_neg;
    logic               r_sign_pend;
    logic [QUO_W-1:0]   r_qest;
    logic [DIG_W-1:0]   r_dig [MAX_DIG];
    logic [CNT_W-1:0]   r_ndig;
    logic [CNT_W-1:0]   r_idx;
    logic [CHAR_W-1:0]  r_char;
    logic               r_last;
    logic               r_long;

    logic [PROD_W-1:0]  prod;
    logic [VALUE_W:0]   q62;
    logic [VALUE_W:0]   rem_full;
    logic               rem_over;
    logic [QUO_W-1:0]   n_quo;
    logic [DIG_W-1:0]   n_digit;
    logic [CNT_W-1:0]   txt_len;
    logic               too_long;
    logic               emit_last;

    always_comb begin
        prod     = PROD_W'(r_mag) * PROD_W'(RECIP_62);
        q62      = {r_qest, 6'b0}
                 - {(VALUE_W - QUO_W)'(0), r_qest, 1'b0};
        rem_full = {1'b0, r_mag} - q62;
        rem_over = rem_full[DIG_W:0] >= RADIX;
        n_quo    = rem_over ? r_qest + QUO_W'(1) : r_qest;
        n_digit  = rem_over ? DIG_W'(rem_full[DIG_W:0] - RADIX) : rem_full[DIG_W-1:0];
        txt_len  = r_ndig + CNT_W'(r_neg);
        too_long = {(BL_W - CNT_W)'(0), txt_len} >= r_bl;
        emit_last = too_long || (!r_sign_pend && r_idx == '0);
        o_stat.quo_zero = n_quo == '0;
        o_stat.last     = emit_last;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_bl <= BL_RESET;
        end else if (i_cfg_we) begin
            r_bl <= i_cfg_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_neg       <= i_value[VALUE_W-1];
            r_sign_pend <= i_value[VALUE_W-1];
            r_mag       <= i_value[VALUE_W-1] ? ~i_value + VALUE_W'(1) : i_value;
            r_ndig      <= '0;
        end
        if (i_cmd.mul) begin
            r_qest <= prod[PROD_W-1:RECIP_SH];
        end
        if (i_cmd.fix) begin
            r_dig[r_ndig] <= n_digit;
            r_ndig        <= r_ndig + CNT_W'(1);
            r_idx         <= r_ndig;
            r_mag         <= {(VALUE_W - QUO_W)'(0), n_quo};
        end
        if (i_cmd.emit) begin
            r_last <= emit_last;
            r_long <= too_long;
            if (too_long) begin
                r_char <= CHAR_NONE;
            end else if (r_sign_pend) begin
                r_char      <= CHAR_MINUS;
                r_sign_pend <= 1'b0;
            end else begin
                r_char <= digit_char(r_dig[r_idx]);
                r_idx  <= r_idx - CNT_W'(1);
            end
        end
    end

    assign o_char_code = r_char;
    assign o_is_last   = r_last;
    assign o_too_long  = r_long;

endmodule

`default_nettype wire

// ===== sv/b62txt_ctrl.sv =====
`default_nettype none

module b62txt_ctrl (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               i_valid,
    output logic                    o_ready,
    output logic                    o_valid,
    input  wire logic               i_ready,
    input  wire b62txt_pkg::t_stat  i_stat,
    output b62txt_pkg::t_cmd        o_cmd
);
    import b62txt_pkg::*;

    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_MUL  = 2'd1;
    localparam logic [1:0] S_FIX  = 2'd2;
    localparam logic [1:0] S_EMIT = 2'd3;

    logic [1:0] r_state;
    logic [1:0] n_state;
    logic       r_out_valid;
    logic       n_out_valid;
    logic       slot_free;

    always_comb begin
        slot_free   = !r_out_valid || i_ready;
        o_cmd       = '0;
        n_state     = r_state;
        n_out_valid = r_out_valid && !i_ready;
        case (r_state)
            S_IDLE: begin
                if (i_valid) begin
                    o_cmd.load = 1'b1;
                    n_state    = S_MUL;
                end
            end
            S_MUL: begin
                o_cmd.mul = 1'b1;
                n_state   = S_FIX;
            end
            S_FIX: begin
                o_cmd.fix = 1'b1;
                n_state   = i_stat.quo_zero ? S_EMIT : S_MUL;
            end
            S_EMIT: begin
                if (slot_free) begin
                    o_cmd.emit  = 1'b1;
                    n_out_valid = 1'b1;
                    if (i_stat.last) begin
                        n_state = S_IDLE;
                    end
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    assign o_ready = r_state == S_IDLE;
    assign o_valid = r_out_valid;

endmodule

`default_nettype wire
